/* hdl/eihp_pkg.sv */
package eihp_pkg;

  // Byte counter width; saturates at its all-ones value
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  // Header geometry in bytes
  localparam int ETH_HDR_BYTES  = 14;
  localparam int IP_MIN_BYTES   = 20;
  localparam int IP_MAX_BYTES   = 60;
  localparam int TCP_HDR_BYTES  = 20;
  localparam int SMALL_L4_BYTES = 8;
  localparam int IHL_W          = 4;

  // Protocol and field codes
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [3:0]  IPV4_VERSION = 4'd4;
  localparam logic [15:0] FRAG_MASK    = 16'h1FFF;
  localparam logic [7:0]  PROTO_ICMP   = 8'h01;
  localparam logic [7:0]  PROTO_TCP    = 8'h06;
  localparam logic [7:0]  PROTO_UDP    = 8'h11;
  localparam int          FLAG_W       = 6;

  // Result status codes
  typedef enum logic [1:0] {
    ST_NON_IP = 2'd0,
    ST_IP_ONLY = 2'd1,
    ST_IP_L4 = 2'd2,
    ST_BAD = 2'd3
  } status_t;

  // Header fields captured so far in the current frame
  typedef struct packed {
    logic [CNT_W-1:0]  byte_count;
    logic [47:0]       dst_mac;
    logic [47:0]       src_mac;
    logic [15:0]       ethertype;
    logic [7:0]        ver_ihl;
    logic [7:0]        ttl;
    logic [7:0]        proto;
    logic [15:0]       tot_len;
    logic [15:0]       frag_word;
    logic [63:0]       ip_addrs;
    logic [31:0]       l4_bytes;
    logic [FLAG_W-1:0] l4_flags;
  } hdr_t;

  // One result item; the last member sits in the lowest bits
  typedef struct packed {
    logic [15:0]       icmp_type_code;
    logic [FLAG_W-1:0] tcp_flag_bits;
    logic [31:0]       port_pair;
    logic [15:0]       ip_total_length;
    logic [7:0]        time_to_live;
    logic [7:0]        ip_protocol;
    logic [31:0]       dst_ip;
    logic [31:0]       src_ip;
    logic [15:0]       ethertype;
    logic [47:0]       src_mac;
    logic [47:0]       dst_mac;
    logic [1:0]        status;
  } res_t;

  localparam int OUT_W = $bits(res_t);

endpackage

/* hdl/ethernet_ipv4_header_parser.sv */
// Takes one frame byte per cycle unless the input stalls as described below.
// The frame's last byte is held in the input register and moves on to the result
// register once it can advance; out_tvalid is driven from that result register.
// Throughput: one byte per cycle; input stalls only while a frame's last byte
// waits behind a result that has not been taken.
// Reset (rst_n low, synchronous) clears all captured fields and valid flags.
module ethernet_ipv4_header_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] data_byte
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [1:0] status, [49:2] dst_mac, [97:50] src_mac, [113:98] ethertype,
  // [145:114] src_ip, [177:146] dst_ip, [185:178] ip_protocol,
  // [193:186] time_to_live, [209:194] ip_total_length, [241:210] port_pair,
  // [247:242] tcp_flag_bits, [263:248] icmp_type_code
  output logic [eihp_pkg::OUT_W-1:0] out_tdata
);

  logic           in_vld_r;
  logic [7:0]     in_data_r;
  logic           in_last_r;
  logic           out_vld_r;
  eihp_pkg::res_t out_r;
  eihp_pkg::hdr_t hdr_nxt;
  eihp_pkg::res_t res;
  logic           advance;

  // Move the held byte on unless its result would overwrite a pending one
  assign advance = in_vld_r && (!in_last_r || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  eihp_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_data_r),
    .last      (in_last_r),
    .hdr_nxt   (hdr_nxt)
  );

  eihp_classify u_classify (
    .hdr (hdr_nxt),
    .res (res)
  );

  // Result register: load on the last byte, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = out_r;

endmodule

/* hdl/eihp_capture.sv */
module eihp_capture (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     data_byte,
  input  logic           last,
  output eihp_pkg::hdr_t hdr_nxt
);

  localparam int CW = eihp_pkg::CNT_W;

  // Byte positions of the captured fields
  localparam logic [CW-1:0] POS_SRC_MAC  = CW'(6);
  localparam logic [CW-1:0] POS_ETYPE    = CW'(12);
  localparam logic [CW-1:0] POS_VER_IHL  = CW'(14);
  localparam logic [CW-1:0] POS_TLEN_HI  = CW'(16);
  localparam logic [CW-1:0] POS_TLEN_LO  = CW'(17);
  localparam logic [CW-1:0] POS_FRAG_HI  = CW'(20);
  localparam logic [CW-1:0] POS_FRAG_LO  = CW'(21);
  localparam logic [CW-1:0] POS_TTL      = CW'(22);
  localparam logic [CW-1:0] POS_PROTO    = CW'(23);
  localparam logic [CW-1:0] POS_ADDRS    = CW'(26);
  localparam logic [CW-1:0] POS_IP_END   = CW'(34);
  localparam logic [CW-1:0] PORT_BYTES   = CW'(4);
  localparam logic [CW-1:0] FLAG_OFFSET  = CW'(13);

  eihp_pkg::hdr_t hdr_r;

  logic [CW-1:0]                pos;
  logic [eihp_pkg::IHL_W-1:0]   ihl;
  logic [CW-1:0]                tpos;

  assign pos = hdr_r.byte_count;

  // Transport header start, using the IHL nibble as it arrives
  always_comb begin
    ihl = (pos == POS_VER_IHL) ? data_byte[3:0] : hdr_r.ver_ihl[3:0];
    tpos = CW'(eihp_pkg::ETH_HDR_BYTES) + CW'({ihl, 2'b00});
  end

  // Capture the byte at its frame position
  always_comb begin
    hdr_nxt = hdr_r;
    if (pos < POS_SRC_MAC) begin
      hdr_nxt.dst_mac = {hdr_r.dst_mac[39:0], data_byte};
    end else if (pos < POS_ETYPE) begin
      hdr_nxt.src_mac = {hdr_r.src_mac[39:0], data_byte};
    end else if (pos < POS_VER_IHL) begin
      hdr_nxt.ethertype = {hdr_r.ethertype[7:0], data_byte};
    end else if (pos == POS_VER_IHL) begin
      hdr_nxt.ver_ihl = data_byte;
    end else if (pos == POS_TLEN_HI || pos == POS_TLEN_LO) begin
      hdr_nxt.tot_len = {hdr_r.tot_len[7:0], data_byte};
    end else if (pos == POS_FRAG_HI || pos == POS_FRAG_LO) begin
      hdr_nxt.frag_word = {hdr_r.frag_word[7:0], data_byte};
    end else if (pos == POS_TTL) begin
      hdr_nxt.ttl = data_byte;
    end else if (pos == POS_PROTO) begin
      hdr_nxt.proto = data_byte;
    end else if (pos >= POS_ADDRS && pos < POS_IP_END) begin
      hdr_nxt.ip_addrs = {hdr_r.ip_addrs[55:0], data_byte};
    end

    // Transport bytes lie past the fixed IPv4 fields
    if (pos >= tpos && pos < tpos + PORT_BYTES && pos >= POS_IP_END) begin
      hdr_nxt.l4_bytes = {hdr_r.l4_bytes[23:0], data_byte};
    end else if (pos == tpos + FLAG_OFFSET && pos >= POS_IP_END) begin
      hdr_nxt.l4_flags = data_byte[eihp_pkg::FLAG_W-1:0];
    end

    // Saturate the byte counter
    if (pos < eihp_pkg::COUNT_MAX) begin
      hdr_nxt.byte_count = pos + CW'(1);
    end
  end

  // Advance on each byte, clear after the frame's last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
    end else if (step) begin
      if (last) begin
        hdr_r <= '0;
      end else begin
        hdr_r <= hdr_nxt;
      end
    end
  end

endmodule

/* hdl/eihp_classify.sv */
module eihp_classify (
  input  eihp_pkg::hdr_t hdr,
  output eihp_pkg::res_t res
);

  localparam int CW = eihp_pkg::CNT_W;

  logic [CW-1:0]              len;
  logic [eihp_pkg::IHL_W-1:0] ihl;
  logic [CW-1:0]              tpos;
  logic [5:0]                 ihl_bytes;
  logic                       ip_bad;
  logic                       ip_out;
  logic                       ports_out;
  logic                       flags_out;
  logic                       icmp_out;
  eihp_pkg::status_t          status;

  always_comb begin
    len = hdr.byte_count;
    ihl = hdr.ver_ihl[3:0];
    ihl_bytes = {ihl, 2'b00};
    tpos = CW'(eihp_pkg::ETH_HDR_BYTES) + CW'(ihl_bytes);
    ip_bad = (len < CW'(eihp_pkg::ETH_HDR_BYTES + eihp_pkg::IP_MIN_BYTES)) ||
             (hdr.ver_ihl[7:4] != eihp_pkg::IPV4_VERSION) ||
             (ihl_bytes < 6'(eihp_pkg::IP_MIN_BYTES)) ||
             (ihl_bytes > 6'(eihp_pkg::IP_MAX_BYTES)) ||
             (len < tpos);
  end

  // Decide status and which field groups are meaningful
  always_comb begin
    ip_out = 1'b0;
    ports_out = 1'b0;
    flags_out = 1'b0;
    icmp_out = 1'b0;
    status = eihp_pkg::ST_BAD;
    if (len < CW'(eihp_pkg::ETH_HDR_BYTES)) begin
      status = eihp_pkg::ST_BAD;
    end else if (hdr.ethertype != eihp_pkg::ETYPE_IPV4) begin
      status = eihp_pkg::ST_NON_IP;
    end else if (ip_bad) begin
      status = eihp_pkg::ST_BAD;
    end else begin
      ip_out = 1'b1;
      if ((hdr.frag_word & eihp_pkg::FRAG_MASK) != '0) begin
        status = eihp_pkg::ST_IP_ONLY;
      end else begin
        unique case (hdr.proto)
          eihp_pkg::PROTO_TCP: begin
            if (len < tpos + CW'(eihp_pkg::TCP_HDR_BYTES)) begin
              status = eihp_pkg::ST_BAD;
            end else begin
              status = eihp_pkg::ST_IP_L4;
              ports_out = 1'b1;
              flags_out = 1'b1;
            end
          end
          eihp_pkg::PROTO_UDP: begin
            if (len < tpos + CW'(eihp_pkg::SMALL_L4_BYTES)) begin
              status = eihp_pkg::ST_BAD;
            end else begin
              status = eihp_pkg::ST_IP_L4;
              ports_out = 1'b1;
            end
          end
          eihp_pkg::PROTO_ICMP: begin
            if (len < tpos + CW'(eihp_pkg::SMALL_L4_BYTES)) begin
              status = eihp_pkg::ST_BAD;
            end else begin
              status = eihp_pkg::ST_IP_L4;
              icmp_out = 1'b1;
            end
          end
          default: begin
            status = eihp_pkg::ST_IP_ONLY;
          end
        endcase
      end
    end
  end

  // Assemble the result; unreached fields read zero
  always_comb begin
    res = '0;
    res.status = status;
    if (len >= CW'(eihp_pkg::ETH_HDR_BYTES)) begin
      res.dst_mac = hdr.dst_mac;
      res.src_mac = hdr.src_mac;
      res.ethertype = hdr.ethertype;
    end
    if (ip_out) begin
      res.src_ip = hdr.ip_addrs[63:32];
      res.dst_ip = hdr.ip_addrs[31:0];
      res.ip_protocol = hdr.proto;
      res.time_to_live = hdr.ttl;
      res.ip_total_length = hdr.tot_len;
    end
    if (ports_out) begin
      res.port_pair = hdr.l4_bytes;
    end
    if (flags_out) begin
      res.tcp_flag_bits = hdr.l4_flags;
    end
    if (icmp_out) begin
      res.icmp_type_code = hdr.l4_bytes[31:16];
    end
  end

endmodule

/* bench/ethernet_ipv4_header_parser_tb.sv */
module ethernet_ipv4_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eihp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;  // [7:0] data_byte
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  // [1:0] status, [49:2] dst_mac, [97:50] src_mac, [113:98] ethertype,
  // [145:114] src_ip, [177:146] dst_ip, [185:178] ip_protocol,
  // [193:186] time_to_live, [209:194] ip_total_length, [241:210] port_pair,
  // [247:242] tcp_flag_bits, [263:248] icmp_type_code
  logic [OUT_W-1:0]   out_tdata;

  // Header fields seen so far in the frame being predicted
  hdr_t       frame_hdr = '0;
  res_t       results_due[$];
  logic [7:0] frame_q[$];
  int         src_idle_pct = 0;
  int         sink_idle_pct = 0;
  int         fail_count = 0;
  int         bytes_sent = 0;
  int         frames_sent = 0;
  int         cycle_count;

  ethernet_ipv4_header_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Capture one byte into the header fields; return 1 with the header result
  // when the byte closes the frame
  function automatic bit parse_byte(input logic [7:0] b, input logic is_last,
                                    output res_t r);
    int      pos;
    int      ihl;
    int      tpos;
    int      len;
    status_t st;
    bit      show_ip;
    bit      show_ports;
    bit      show_flags;
    bit      show_icmp;
    pos = int'(frame_hdr.byte_count);
    r = '0;
    show_ip = 1'b0;
    show_ports = 1'b0;
    show_flags = 1'b0;
    show_icmp = 1'b0;

    // Capture fixed-position Ethernet and IPv4 fields
    if (pos < 6) begin
      frame_hdr.dst_mac = {frame_hdr.dst_mac[39:0], b};
    end else if (pos < 12) begin
      frame_hdr.src_mac = {frame_hdr.src_mac[39:0], b};
    end else if (pos < ETH_HDR_BYTES) begin
      frame_hdr.ethertype = {frame_hdr.ethertype[7:0], b};
    end else if (pos == 14) begin
      frame_hdr.ver_ihl = b;
    end else if (pos == 16 || pos == 17) begin
      frame_hdr.tot_len = {frame_hdr.tot_len[7:0], b};
    end else if (pos == 20 || pos == 21) begin
      frame_hdr.frag_word = {frame_hdr.frag_word[7:0], b};
    end else if (pos == 22) begin
      frame_hdr.ttl = b;
    end else if (pos == 23) begin
      frame_hdr.proto = b;
    end else if (pos >= 26 && pos < 34) begin
      frame_hdr.ip_addrs = {frame_hdr.ip_addrs[55:0], b};
    end

    // Capture transport bytes relative to the end of the IPv4 header
    ihl = int'(frame_hdr.ver_ihl[3:0]);
    tpos = ETH_HDR_BYTES + ihl * 4;
    if (pos >= tpos && pos < tpos + 4 && pos >= 34) begin
      frame_hdr.l4_bytes = {frame_hdr.l4_bytes[23:0], b};
    end else if (pos == tpos + 13 && pos >= 34) begin
      frame_hdr.l4_flags = b[FLAG_W-1:0];
    end

    // Advance the saturating byte count
    if (frame_hdr.byte_count != COUNT_MAX) begin
      frame_hdr.byte_count = frame_hdr.byte_count + CNT_W'(1);
    end
    if (!is_last) begin
      return 1'b0;
    end

    // Classify the finished frame
    len = int'(frame_hdr.byte_count);
    if (len < ETH_HDR_BYTES) begin
      st = ST_BAD;
    end else begin
      r.dst_mac = frame_hdr.dst_mac;
      r.src_mac = frame_hdr.src_mac;
      r.ethertype = frame_hdr.ethertype;
      if (frame_hdr.ethertype != ETYPE_IPV4) begin
        st = ST_NON_IP;
      end else if (len < ETH_HDR_BYTES + IP_MIN_BYTES ||
                   frame_hdr.ver_ihl[7:4] != IPV4_VERSION ||
                   ihl * 4 < IP_MIN_BYTES || ihl * 4 > IP_MAX_BYTES || len < tpos) begin
        st = ST_BAD;
      end else begin
        show_ip = 1'b1;
        if ((frame_hdr.frag_word & FRAG_MASK) != '0) begin
          st = ST_IP_ONLY;
        end else if (frame_hdr.proto == PROTO_TCP) begin
          if (len < tpos + TCP_HDR_BYTES) begin
            st = ST_BAD;
          end else begin
            st = ST_IP_L4;
            show_ports = 1'b1;
            show_flags = 1'b1;
          end
        end else if (frame_hdr.proto == PROTO_UDP || frame_hdr.proto == PROTO_ICMP) begin
          if (len < tpos + SMALL_L4_BYTES) begin
            st = ST_BAD;
          end else begin
            st = ST_IP_L4;
            show_ports = (frame_hdr.proto == PROTO_UDP);
            show_icmp = (frame_hdr.proto == PROTO_ICMP);
          end
        end else begin
          st = ST_IP_ONLY;
        end
      end
    end

    r.status = st;
    if (show_ip) begin
      r.src_ip = frame_hdr.ip_addrs[63:32];
      r.dst_ip = frame_hdr.ip_addrs[31:0];
      r.ip_protocol = frame_hdr.proto;
      r.time_to_live = frame_hdr.ttl;
      r.ip_total_length = frame_hdr.tot_len;
    end
    if (show_ports) begin
      r.port_pair = frame_hdr.l4_bytes;
    end
    if (show_flags) begin
      r.tcp_flag_bits = frame_hdr.l4_flags;
    end
    if (show_icmp) begin
      r.icmp_type_code = frame_hdr.l4_bytes[31:16];
    end
    frame_hdr = '0;
    return 1'b1;
  endfunction

  // Frame building
  function automatic void add_rand(input int n);
    for (int i = 0; i < n; i++) begin
      frame_q.push_back(8'($urandom));
    end
  endfunction

  function automatic void add_const(input int n, input logic [7:0] v);
    for (int i = 0; i < n; i++) begin
      frame_q.push_back(v);
    end
  endfunction

  function automatic void add_eth(input logic [15:0] etype);
    add_rand(12);
    frame_q.push_back(etype[15:8]);
    frame_q.push_back(etype[7:0]);
  endfunction

  function automatic void cut_frame(input int n);
    while (frame_q.size() > n) begin
      void'(frame_q.pop_back());
    end
  endfunction

  // Ethernet + IPv4 header with options + full transport header + padding
  function automatic void make_ipv4(input logic [3:0] ver, input int ihl,
                                    input logic [15:0] frag, input logic [7:0] proto,
                                    input int pad);
    add_eth(ETYPE_IPV4);
    frame_q.push_back({ver, 4'(ihl)});
    add_rand(5);  // DSCP/ECN, total length, identification
    frame_q.push_back(frag[15:8]);
    frame_q.push_back(frag[7:0]);
    add_rand(1);  // TTL
    frame_q.push_back(proto);
    add_rand(10);  // checksum, addresses
    if (ihl > 5) begin
      add_rand((ihl - 5) * 4);
    end
    add_rand((proto == PROTO_TCP) ? TCP_HDR_BYTES : SMALL_L4_BYTES);
    add_rand(pad);
  endfunction

  // Stream handling: ready is read mid-cycle, ahead of the edge that takes the byte
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= is_last;
    @(negedge clk);
    while (!in_tready) begin
      @(negedge clk);
    end
    @(posedge clk);
    if (parse_byte(b, is_last, r)) begin
      results_due.push_back(r);
    end
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
    frame_q.delete();
    frames_sent++;
  endtask

  // Hold the input idle until every pending result has been checked
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Directed tests
  task automatic test_short_frames();
    add_const(1, 8'hFF);
    send_frame();
    add_const(13, 8'h00);
    send_frame();
    add_eth(ETYPE_IPV4);
    cut_frame(13);
    send_frame();
  endtask

  task automatic test_non_ipv4();
    add_eth(16'h86DD);
    send_frame();
    add_eth(16'h0806);
    add_rand(28);
    send_frame();
  endtask

  task automatic test_extremes();
    add_const(20, 8'h00);
    send_frame();
    add_const(20, 8'hFF);
    send_frame();
    // All-ones IPv4 header: IHL 15, fragment offset set
    add_const(12, 8'hFF);
    frame_q.push_back(ETYPE_IPV4[15:8]);
    frame_q.push_back(ETYPE_IPV4[7:0]);
    frame_q.push_back({IPV4_VERSION, 4'hF});
    add_const(80, 8'hFF);
    send_frame();
    // All-zero IPv4 header with protocol zero
    add_const(12, 8'h00);
    frame_q.push_back(ETYPE_IPV4[15:8]);
    frame_q.push_back(ETYPE_IPV4[7:0]);
    frame_q.push_back({IPV4_VERSION, 4'd5});
    add_const(20, 8'h00);
    send_frame();
  endtask

  task automatic test_bad_ipv4();
    // IPv4 ethertype but too short for the base header
    make_ipv4(IPV4_VERSION, 5, 16'h0000, PROTO_TCP, 0);
    cut_frame(33);
    send_frame();
    make_ipv4(4'd6, 5, 16'h0000, PROTO_TCP, 0);
    send_frame();
    make_ipv4(IPV4_VERSION, 4, 16'h0000, PROTO_UDP, 0);
    send_frame();
    make_ipv4(IPV4_VERSION, 0, 16'h0000, PROTO_UDP, 0);
    send_frame();
    // IHL 15 but frame ends inside the options
    make_ipv4(IPV4_VERSION, 15, 16'h0000, PROTO_UDP, 0);
    cut_frame(70);
    send_frame();
  endtask

  task automatic test_fragment();
    make_ipv4(IPV4_VERSION, 5, 16'h1FFF, PROTO_TCP, 0);
    send_frame();
    make_ipv4(IPV4_VERSION, 5, 16'hE001, PROTO_UDP, 0);
    send_frame();
    // Flag bits alone are not a fragment
    make_ipv4(IPV4_VERSION, 5, 16'hE000, PROTO_UDP, 0);
    send_frame();
  endtask

  task automatic test_transport();
    make_ipv4(IPV4_VERSION, 5, 16'h0000, PROTO_TCP, 0);
    send_frame();
    make_ipv4(IPV4_VERSION, 15, 16'h4000, PROTO_TCP, 2);
    send_frame();
    make_ipv4(IPV4_VERSION, 5, 16'h0000, PROTO_UDP, 4);
    send_frame();
    make_ipv4(IPV4_VERSION, 6, 16'h0000, PROTO_ICMP, 0);
    send_frame();
    make_ipv4(IPV4_VERSION, 5, 16'h0000, 8'h00, 0);
    send_frame();
    make_ipv4(IPV4_VERSION, 5, 16'h0000, 8'hFF, 0);
    send_frame();
  endtask

  task automatic test_truncated_transport();
    make_ipv4(IPV4_VERSION, 5, 16'h0000, PROTO_TCP, 0);
    cut_frame(53);
    send_frame();
    make_ipv4(IPV4_VERSION, 5, 16'h0000, PROTO_UDP, 0);
    cut_frame(41);
    send_frame();
    // Frame ends exactly at the end of the IPv4 header
    make_ipv4(IPV4_VERSION, 7, 16'h0000, PROTO_ICMP, 0);
    cut_frame(42);
    send_frame();
  endtask

  task automatic test_counter_saturation();
    make_ipv4(IPV4_VERSION, 5, 16'h0000, PROTO_TCP, 80);
    send_frame();
  endtask

  // Random frames: mostly well-formed IPv4 with random content, the rest cut short, malformed or random
  task automatic test_random(input int src_pct, input int sink_pct, input int n_bytes);
    int         kind;
    int         ihl;
    int         stop_at;
    int         min_frames;
    logic [3:0] ver;
    logic [7:0] proto;
    logic [15:0] frag;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    stop_at = bytes_sent + n_bytes;
    min_frames = frames_sent + 1;
    while (bytes_sent < stop_at || frames_sent < min_frames) begin
      kind = $urandom_range(99);
      ihl = ($urandom_range(3) != 0) ? 5 : $urandom_range(15, 6);
      case ($urandom_range(9))
        0, 1, 2: proto = PROTO_TCP;
        3, 4:    proto = PROTO_UDP;
        5, 6:    proto = PROTO_ICMP;
        default: proto = 8'($urandom);
      endcase
      if ($urandom_range(9) == 0) begin
        frag = {3'($urandom), 13'($urandom_range(8191, 1))};
      end else begin
        frag = {3'($urandom), 13'd0};
      end
      if (kind < 55) begin
        make_ipv4(IPV4_VERSION, ihl, frag, proto, $urandom_range(4));
      end else if (kind < 65) begin
        make_ipv4(IPV4_VERSION, ihl, frag, proto, 0);
        cut_frame($urandom_range(frame_q.size() - 1, ETH_HDR_BYTES + 1));
      end else if (kind < 73) begin
        if ($urandom_range(1) != 0) begin
          ver = 4'(IPV4_VERSION + $urandom_range(15, 1));
          ihl = $urandom_range(15);
        end else begin
          ver = IPV4_VERSION;
          ihl = $urandom_range(4);
        end
        make_ipv4(ver, ihl, frag, proto, 0);
      end else if (kind < 83) begin
        add_eth(16'($urandom));
        add_rand($urandom_range(50));
      end else if (kind < 91) begin
        add_rand($urandom_range(13, 1));
      end else if (kind < 97) begin
        add_rand($urandom_range(80, 1));
      end else begin
        make_ipv4(IPV4_VERSION, ihl, frag, proto, $urandom_range(100, 80));
      end
      send_frame();
    end
  endtask

  // Compare one result field
  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endfunction

  // Stall the result channel at random
  always @(posedge clk) begin : sink_ready
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Check each result transfer mid-cycle, ahead of the edge that takes it
  always @(negedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (results_due.size() == 0) begin
        $error("result with none pending: %h", got);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("dst_mac", 64'(want.dst_mac), 64'(got.dst_mac));
        check_field("src_mac", 64'(want.src_mac), 64'(got.src_mac));
        check_field("ethertype", 64'(want.ethertype), 64'(got.ethertype));
        check_field("src_ip", 64'(want.src_ip), 64'(got.src_ip));
        check_field("dst_ip", 64'(want.dst_ip), 64'(got.dst_ip));
        check_field("ip_protocol", 64'(want.ip_protocol), 64'(got.ip_protocol));
        check_field("time_to_live", 64'(want.time_to_live), 64'(got.time_to_live));
        check_field("ip_total_length", 64'(want.ip_total_length),
                    64'(got.ip_total_length));
        check_field("port_pair", 64'(want.port_pair), 64'(got.port_pair));
        check_field("tcp_flag_bits", 64'(want.tcp_flag_bits), 64'(got.tcp_flag_bits));
        check_field("icmp_type_code", 64'(want.icmp_type_code),
                    64'(got.icmp_type_code));
      end
    end
  end

  // Bound the run
  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
      @(posedge clk);
    end
    $display("** ethernet_ipv4_header_parser: FAILED **");
    $finish;
  end

  initial begin
    src_idle_pct = 14;
    sink_idle_pct = 78;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_short_frames();
    test_non_ipv4();
    test_extremes();
    test_bad_ipv4();
    test_fragment();
    test_transport();
    test_truncated_transport();
    test_counter_saturation();
    wait_drained();

    test_random(14, 78, 20);
    test_random(78, 14, 20);
    test_random(0, 0, 20);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** ethernet_ipv4_header_parser: PASSED **");
    end else begin
      $display("** ethernet_ipv4_header_parser: FAILED **");
    end
    $finish;
  end

endmodule
